// ----- rtl/assert_macros.svh -----
// Assertion helpers included by the RTL top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_AT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/rop_pkg.sv -----
package rop_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int OCC_W     = 5;

  typedef enum logic {
    REQ_INSERT,
    REQ_POP
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_INSERTED,
    ST_POPPED,
    ST_FULL,
    ST_EMPTY
  } status_t;

  typedef struct packed {
    req_kind_t   req_type;
    logic [31:0] entry_name;
    logic [7:0]  entry_rank;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [31:0]      out_name;
    logic [7:0]       out_rank;
    logic [OCC_W-1:0] occupancy;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  rank;
    logic [31:0] name;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t key;
  } cell_ctl_t;

endpackage

// ----- rtl/rop_cell.sv -----
module rop_cell (
  input  logic               clk,
  input  rop_pkg::cell_ctl_t ctl,
  input  logic               occupied,
  input  logic               prev_before,
  input  rop_pkg::entry_t    prev_entry,
  input  rop_pkg::entry_t    next_entry,
  output logic               ahead,
  output rop_pkg::entry_t    entry
);
  import rop_pkg::*;

  entry_t entry_next;

  // held entry sorts at or ahead of the new key
  assign ahead = occupied &&
                 ((entry.rank < ctl.key.rank) ||
                  ((entry.rank == ctl.key.rank) && (entry.name <= ctl.key.name)));

  always_comb begin
    entry_next = entry;
    if (ctl.ins && !ahead) begin
      entry_next = prev_before ? ctl.key : prev_entry;
    end else if (ctl.pop) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ----- rtl/rank_ordered_priority_queue_top.sv -----
// Sorted priority queue of DEPTH entries held in a row of cells, front in cell 0,
// ordered by (rank, name) with equal keys in arrival order. Every cell compares
// its entry with the incoming key in parallel and either holds, loads the key or
// shifts, so one request is taken per cycle and its result appears in the output
// register on the next cycle. The only hold-off is rsp_stall: while a result
// waits, req_stall is high. Insert on a full queue and pop on an empty one leave
// the contents untouched and are reported in status. No clearing pass after reset.
`include "assert_macros.svh"

module rank_ordered_priority_queue_top #(
  parameter int DEPTH = rop_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rop_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rop_pkg::rsp_t rsp
);
  import rop_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic          rsp_valid_next;
  rsp_t          rsp_next;
  cell_ctl_t     ctl;
  entry_t        ent [DEPTH];
  logic          bef [DEPTH];
  logic          occ [DEPTH];
  logic          accept;
  logic          full;
  logic          empty;
  logic          front_ok;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign full      = (cnt == CW'(DEPTH));
  assign empty     = (cnt == '0);

  assign ctl.ins       = accept && (req.req_type == REQ_INSERT) && !full;
  assign ctl.pop       = accept && (req.req_type == REQ_POP) && !empty;
  assign ctl.key.rank  = req.entry_rank;
  assign ctl.key.name  = req.entry_name;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = (cnt > CW'(i));
    rop_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (occ[i]),
      .prev_before((i == 0) ? 1'b1 : bef[(i == 0) ? 0 : i - 1]),
      .prev_entry ((i == 0) ? ctl.key : ent[(i == 0) ? 0 : i - 1]),
      .next_entry ((i == DEPTH - 1) ? ent[i] : ent[(i == DEPTH - 1) ? i : i + 1]),
      .ahead      (bef[i]),
      .entry      (ent[i])
    );
  end

  always_comb begin
    cnt_next = cnt;
    if (ctl.ins) begin
      cnt_next = cnt + CW'(1);
    end else if (ctl.pop) begin
      cnt_next = cnt - CW'(1);
    end

    rsp_next.out_name = '0;
    rsp_next.out_rank = '0;
    if (req.req_type == REQ_INSERT) begin
      rsp_next.status = full ? ST_FULL : ST_INSERTED;
    end else if (empty) begin
      rsp_next.status = ST_EMPTY;
    end else begin
      rsp_next.status   = ST_POPPED;
      rsp_next.out_name = ent[0].name;
      rsp_next.out_rank = ent[0].rank;
    end
    rsp_next.occupancy = OCC_W'(cnt_next);

    rsp_valid_next = accept || (rsp_valid && rsp_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      cnt       <= cnt_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  assign front_ok = ({ent[0].rank, ent[0].name} <= {ent[1].rank, ent[1].name});

  `ASSERT_AT(a_cnt_bound, clk, rst, cnt <= CW'(DEPTH), "count beyond depth")
  `ASSERT_NEXT(a_ins_count, clk, rst, ctl.ins, cnt == $past(cnt) + CW'(1), "insert not counted")
  `ASSERT_IMPL(a_rsp_occ, clk, rst, rsp_valid, rsp.occupancy == OCC_W'(cnt), "occupancy mismatch")
  `ASSERT_IMPL(a_front_order, clk, rst, cnt >= CW'(2), front_ok, "front out of order")

endmodule

// ----- dv/tb_rank_ordered_priority_queue_top.sv -----
module tb_rank_ordered_priority_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rop_pkg::*;

  localparam int QDEPTH         = DEPTH_DEF;
  localparam int RANDOM_ITEMS   = 910;
  localparam int SQUEEZE_AFTER  = 150;
  localparam int SQUEEZE_CYCLES = 300;

  typedef enum int {
    KEY_WIDE,
    KEY_CLASHING,
    KEY_EDGE
  } key_mix_t;

  typedef struct {
    req_t r;
    int   reps;
    bit   pinned;
    rsp_t want;
  } plan_row_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_stall;
  req_t  req = '0;
  logic  rsp_valid;
  logic  rsp_stall = 1'b0;
  rsp_t  rsp;

  // fixed result for pinned directed rows, taken in place of the prediction
  bit    pin_on = 1'b0;
  rsp_t  pin_rsp = '0;

  entry_t q_slot [QDEPTH];
  int     q_count = 0;
  rsp_t   awaited_rsps [$];
  int     bad_fields = 0;
  bit     squeeze_on = 1'b0;
  bit     squeezed = 1'b0;
  int     calm_left = 0;

  rank_ordered_priority_queue_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // sorted queue: new entry goes after every slot whose (rank, name) is not greater
  function automatic rsp_t next_queue_result(req_t r);
    rsp_t   res;
    entry_t key;
    int     pos;
    res = '0;
    key.rank = r.entry_rank;
    key.name = r.entry_name;
    if (r.req_type == REQ_INSERT) begin
      if (q_count >= QDEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        for (int i = 0; i < q_count; i++) begin
          if (q_slot[i] <= key) pos = i + 1;
        end
        for (int i = q_count; i > pos; i--) q_slot[i] = q_slot[i-1];
        q_slot[pos] = key;
        q_count++;
        res.status = ST_INSERTED;
      end
    end else begin
      if (q_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.out_name = q_slot[0].name;
        res.out_rank = q_slot[0].rank;
        for (int i = 1; i < q_count; i++) q_slot[i-1] = q_slot[i];
        q_count--;
        res.status = ST_POPPED;
      end
    end
    res.occupancy = OCC_W'(q_count);
    return res;
  endfunction

  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic req_t make_req(int ins_pct, key_mix_t mix);
    req_t r;
    r.req_type = ($urandom_range(0, 99) < ins_pct) ? REQ_INSERT : REQ_POP;
    case (mix)
      KEY_CLASHING: begin
        r.entry_rank = 8'($urandom_range(0, 3));
        r.entry_name = {24'h414e41, 6'd0, 2'($urandom_range(0, 3))};
      end
      KEY_EDGE: begin
        r.entry_rank = $urandom_range(0, 1) ? 8'hff : 8'h00;
        case ($urandom_range(0, 2))
          0:       r.entry_name = 32'h0;
          1:       r.entry_name = 32'hffff_ffff;
          default: r.entry_name = {8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
                                   16'h0};
        endcase
      end
      default: begin
        r.entry_rank = 8'($urandom);
        r.entry_name = $urandom;
      end
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, field, got, want);
    bad_fields++;
  endtask

  task automatic send_req(req_t r, bit pinned, rsp_t want);
    int gap;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(20, 60);
      gap = idle_len();
    end
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    pin_on    <= pinned;
    pin_rsp   <= want;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    rsp_t want;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        want = next_queue_result(req);
        if (pin_on) want = pin_rsp;
        awaited_rsps.push_back(want);
      end
      if (rsp_valid && !rsp_stall) begin
        if (awaited_rsps.size() == 0) begin
          flag_mismatch("unexpected result", 32'(rsp.status), 32'h0);
        end else begin
          want = awaited_rsps.pop_front();
          if (rsp.status !== want.status)
            flag_mismatch("status", 32'(rsp.status), 32'(want.status));
          if (rsp.out_name !== want.out_name)
            flag_mismatch("out_name", rsp.out_name, want.out_name);
          if (rsp.out_rank !== want.out_rank)
            flag_mismatch("out_rank", 32'(rsp.out_rank), 32'(want.out_rank));
          if (rsp.occupancy !== want.occupancy)
            flag_mismatch("occupancy", 32'(rsp.occupancy), 32'(want.occupancy));
        end
      end
    end
  end

  always begin : rsp_side
    int hold;
    @(posedge clk);
    if (!rst) begin
      if (squeeze_on && !squeezed) begin
        hold = SQUEEZE_CYCLES;
        squeezed = 1'b1;
      end else begin
        hold = idle_len();
      end
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(30, 80)) @(posedge clk);
      else repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    plan_row_t plan [12];
    int        ins_pct;
    int        phase_left;
    key_mix_t  mix;
    plan = '{
      '{'{REQ_POP,    32'h0,         8'h00}, 1,  1'b1, '{ST_EMPTY,    32'h0, 8'h0, 5'd0}},
      '{'{REQ_INSERT, 32'hffff_ffff, 8'hff}, 1,  1'b1, '{ST_INSERTED, 32'h0, 8'h0, 5'd1}},
      '{'{REQ_INSERT, 32'h0,         8'h00}, 1,  1'b1, '{ST_INSERTED, 32'h0, 8'h0, 5'd2}},
      '{'{REQ_INSERT, 32'h4142_4300, 8'h07}, 1,  1'b0, '0},
      '{'{REQ_INSERT, 32'h4142_4300, 8'h07}, 1,  1'b0, '0},
      // zero byte ahead of letters: whole word compared
      '{'{REQ_INSERT, 32'h0041_4243, 8'h07}, 1,  1'b0, '0},
      '{'{REQ_POP,    32'h0,         8'h00}, 1,  1'b1, '{ST_POPPED,   32'h0, 8'h0, 5'd4}},
      '{'{REQ_POP,    32'hdead_beef, 8'h5a}, 1,  1'b0, '0},
      '{'{REQ_INSERT, 32'h4245_4400, 8'h80}, 13, 1'b0, '0},
      '{'{REQ_INSERT, 32'h0000_0001, 8'h01}, 1,  1'b1, '{ST_FULL,     32'h0, 8'h0, 5'd16}},
      '{'{REQ_POP,    32'h0,         8'h00}, 16, 1'b0, '0},
      '{'{REQ_POP,    32'h0,         8'h00}, 1,  1'b1, '{ST_EMPTY,    32'h0, 8'h0, 5'd0}}
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      repeat (plan[i].reps) send_req(plan[i].r, plan[i].pinned, plan[i].want);
    end

    phase_left = 0;
    ins_pct    = 50;
    mix        = KEY_WIDE;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0:       ins_pct = 90;
          1:       ins_pct = 50;
          default: ins_pct = 10;
        endcase
        case ($urandom_range(0, 3))
          0, 1:    mix = KEY_WIDE;
          2:       mix = KEY_CLASHING;
          default: mix = KEY_EDGE;
        endcase
      end
      phase_left--;
      if (n == SQUEEZE_AFTER) squeeze_on = 1'b1;
      send_req(make_req(ins_pct, mix), 1'b0, '0);
    end
    req_valid <= 1'b0;

    while (awaited_rsps.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (bad_fields == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
